// File: hdl/tli_pkg.sv
`default_nettype none
package tli_pkg;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned LEN_W  = 9;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // word handed from the front part to the back part
  typedef struct packed {
    op_t                opcode;
    logic [IDX_W-1:0]   entry_index;
    logic [DATA_W-1:0]  x_value;
    logic [DATA_W-1:0]  y_value;
  } item_t;
endpackage
`default_nettype wire

// File: hdl/tli_front.sv
`default_nettype none
module tli_front
  import tli_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_word,
  output logic       q_valid,
  input  wire logic  q_ready,
  output item_t      q_word
);
  // two-entry queue between intake and execution
  item_t     mem [2];
  logic      wptr;
  logic      rptr;
  logic [1:0] count;
  logic      push;
  logic      pop;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_word   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_word;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: hdl/tli_back.sv
`default_nettype none
module tli_back
  import tli_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [LEN_W-1:0]  table_length,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire item_t             q_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      result
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_CHK0, S_RDL, S_CHKL, S_SRCH, S_RDB, S_SETUP, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state;
  logic [DATA_W-1:0] xmem [DEPTH];
  logic [DATA_W-1:0] ymem [DEPTH];
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] xr, yr;
  logic signed [DATA_W-1:0] x0, xi, yi;
  logic [AW:0]       n;
  logic [AW:0]       ci;
  logic [63:0]       rem;
  logic [63:0]       quo;
  logic [32:0]       dxr;
  logic              neg;
  logic [6:0]        step;
  logic [AW:0]       n_eff;
  logic [32:0]       dx, dd, dy_mag;
  logic signed [32:0] dy;
  logic [64:0]       trial;

  // clamp the length in use
  always_comb begin
    if (table_length < LEN_W'(2)) n_eff = (AW+1)'(2);
    else if (32'(table_length) > DEPTH) n_eff = (AW+1)'(DEPTH);
    else n_eff = (AW+1)'(table_length);
  end

  assign dx     = 33'($signed(xr)) - 33'(xi);
  assign dd     = 33'(x0) - 33'(xi);
  assign dy     = $signed({yr[31], yr}) - $signed({yi[31], yi});
  assign dy_mag = dy[32] ? 33'(-dy) : 33'(dy);
  assign trial  = {rem[63:0], quo[63]} - {32'd0, dxr};

  assign q_ready   = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid && q_word.opcode == OP_WRITE &&
        32'(q_word.entry_index) < DEPTH) begin
      xmem[AW'(q_word.entry_index)] <= q_word.x_value;
      ymem[AW'(q_word.entry_index)] <= q_word.y_value;
    end
    xr <= xmem[raddr];
    yr <= ymem[raddr];
  end

  // sequencer: clamp checks, linear search, restoring divide
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid && q_word.opcode == OP_QUERY) begin
            x0    <= $signed(q_word.x_value);
            n     <= n_eff;
            raddr <= '0;
            state <= S_RD0;
          end
        end
        S_RD0: state <= S_CHK0;
        S_CHK0: begin
          if ($signed(xr) >= x0) begin
            result <= yr;
            state  <= S_OUT;
          end else begin
            xi    <= $signed(xr);
            yi    <= $signed(yr);
            raddr <= AW'(n - 1'b1);
            state <= S_RDL;
          end
        end
        S_RDL: state <= S_CHKL;
        S_CHKL: begin
          if ($signed(xr) <= x0) begin
            result <= yr;
            state  <= S_OUT;
          end else begin
            ci    <= (AW+1)'(1);
            raddr <= AW'(1);
            state <= S_RDB;
          end
        end
        S_RDB: state <= S_SRCH;
        S_SRCH: begin
          // xr,yr hold entry ci; xi,yi hold entry ci-1
          if (ci + 1'b1 < n && x0 > $signed(xr)) begin
            xi    <= $signed(xr);
            yi    <= $signed(yr);
            ci    <= ci + 1'b1;
            raddr <= AW'(ci + 1'b1);
            state <= S_RDB;
          end else begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if ($signed(dx) <= 0) begin
            result <= yi;
            state  <= S_OUT;
          end else begin
            quo   <= 64'(dy_mag) * 64'(dd[32] ? 33'd0 : dd);
            rem   <= '0;
            dxr   <= dx;
            neg   <= dy[32];
            step  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // one quotient bit a cycle
          if (!trial[64]) begin
            rem <= trial[63:0];
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= {rem[62:0], quo[63]};
            quo <= {quo[62:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == 7'd63) state <= S_FIN;
        end
        S_FIN: begin
          result <= neg ? yi - quo[31:0] : yi + quo[31:0];
          state  <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/table_linear_interpolator.sv
`default_nettype none
// Piecewise linear lookup over a table of TABLE_DEPTH (x, y) Q16.16 breakpoints.
// Write words (opcode 0) load one entry and give no result; query words
// (opcode 1) return one clamped or interpolated y. A query that is not
// clamped runs a linear search over the segments and then the bit-serial
// 64-bit divider; the linear search dominates on long tables. A two-word
// queue lets input be taken while the back part works.
module table_linear_interpolator
  import tli_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [LEN_W-1:0]         cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     opcode,
  input  wire logic [IDX_W-1:0]         entry_index,
  input  wire logic signed [DATA_W-1:0] x_value,
  input  wire logic signed [DATA_W-1:0] y_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      interpolated_value
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [LEN_W-1:0] table_length;
  item_t in_word, q_word;
  logic q_valid, q_ready;
  logic [DATA_W-1:0] res;

  // hold the length register
  always_ff @(posedge clk) begin
    if (rst) table_length <= LEN_W'(256);
    else if (cfg_we) table_length <= cfg_data;
  end

  assign in_word = '{opcode: op_t'(opcode), entry_index: entry_index,
                     x_value: x_value, y_value: y_value};
  assign interpolated_value = $signed(res);

  tli_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_word,
    .q_valid, .q_ready, .q_word
  );

  tli_back #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_back (
    .clk, .rst, .table_length, .q_valid, .q_ready, .q_word,
    .out_valid, .out_ready, .result(res)
  );
endmodule
`default_nettype wire

// File: tb/tli_checker.sv
module tli_checker
  import tli_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [LEN_W-1:0]         cfg_data,
  input  wire logic                     in_valid,
  input  wire logic                     in_ready,
  input  wire logic                     opcode,
  input  wire logic [IDX_W-1:0]         entry_index,
  input  wire logic signed [DATA_W-1:0] x_value,
  input  wire logic signed [DATA_W-1:0] y_value,
  input  wire logic                     out_valid,
  input  wire logic                     out_ready,
  input  wire logic signed [DATA_W-1:0] interpolated_value,
  output int                            fail_count,
  output int                            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 256;

  logic signed [63:0] bp_x [DEPTH];
  logic signed [63:0] bp_y [DEPTH];
  logic [LEN_W-1:0] used_len;
  logic signed [DATA_W-1:0] interp_queue [$];

  assign pending_count = interp_queue.size();

  // Compute the clamped or interpolated y for a query point
  function automatic logic signed [DATA_W-1:0] interp_at(logic signed [63:0] x0);
    int n;
    int i;
    logic signed [63:0] dx;
    logic signed [63:0] d;
    logic signed [63:0] dy;
    logic [63:0] mag;
    logic [63:0] q;
    n = used_len;
    if (n < 2) n = 2;
    if (n > DEPTH) n = DEPTH;
    i = 0;
    if (bp_x[0] >= x0) return bp_y[0][31:0];
    if (bp_x[n-1] <= x0) return bp_y[n-1][31:0];
    while (i + 2 < n && x0 > bp_x[i+1]) i++;
    dx = bp_x[i+1] - bp_x[i];
    if (dx <= 0) return bp_y[i][31:0];
    d = x0 - bp_x[i];
    if (d < 0) d = 0;
    dy = bp_y[i+1] - bp_y[i];
    mag = (dy < 0) ? -dy : dy;
    q = (mag * d) / dx;
    return (dy < 0) ? 32'(bp_y[i] - q) : 32'(bp_y[i] + q);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    used_len = LEN_W'(256);
    for (int k = 0; k < DEPTH; k++) begin
      bp_x[k] = 0;
      bp_y[k] = 0;
    end
  end

  always @(posedge clk) begin
    logic signed [DATA_W-1:0] want;
    if (rst) begin
      used_len <= LEN_W'(256);
    end else begin
      // Track the length register
      if (cfg_we) used_len <= cfg_data;
      // Apply write words and predict query words
      if (in_valid && in_ready) begin
        if (op_t'(opcode) == OP_WRITE) begin
          bp_x[entry_index] = 64'(x_value);
          bp_y[entry_index] = 64'(y_value);
        end else begin
          interp_queue.push_back(interp_at(64'(x_value)));
        end
      end
      // Compare each result word with the oldest prediction
      if (out_valid && out_ready) begin
        if (interp_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", interpolated_value));
        end else begin
          want = interp_queue.pop_front();
          if (interpolated_value !== want)
            report_mismatch($sformatf("interpolated_value got %0d want %0d",
                                      interpolated_value, want));
        end
      end
    end
  end
endmodule

// File: tb/tb_top.sv
module tb_top;
  import tli_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = 1'b0;
  logic [IDX_W-1:0] entry_index = '0;
  logic signed [DATA_W-1:0] x_value = '0;
  logic signed [DATA_W-1:0] y_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] interpolated_value;
  int fail_count;
  int pending_count;
  int idle_cycles = 0;
  bit quiet_tail = 0;
  bit sink_on = 0;
  logic signed [DATA_W-1:0] bp_xs [256];

  always #2 clk = ~clk;

  table_linear_interpolator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .entry_index(entry_index), .x_value(x_value), .y_value(y_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .interpolated_value(interpolated_value)
  );

  tli_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .entry_index(entry_index), .x_value(x_value), .y_value(y_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .interpolated_value(interpolated_value),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("table_linear_interpolator: mismatch");
        $finish;
      end
    end
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (!sink_on || quiet_tail) begin
      out_ready <= sink_on;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Drive one word and hold it until taken
  task automatic send_word(op_t op, int idx, logic [31:0] xv, logic [31:0] yv);
    if (!quiet_tail && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 18)) @(negedge clk);
    in_valid = 1'b1;
    opcode <= op;
    entry_index <= idx[7:0];
    x_value <= xv;
    y_value <= yv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain_then_set_len(int len);
    while (pending_count != 0) @(negedge clk);
    repeat (700) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= len[8:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Load an ascending table, with some flat steps and equal neighbors
  task automatic load_table(int n, bit wide);
    logic signed [31:0] xv;
    logic [31:0] yv;
    xv = wide ? 32'sh8000_0000 + $urandom_range(0, 1000) : -$urandom_range(0, 1 << 20);
    for (int k = 0; k < n; k++) begin
      yv = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000)
                                       : $urandom();
      bp_xs[k] = xv;
      send_word(OP_WRITE, k, xv, yv);
      if (wide) xv = xv + (32'h7fff_ff00 / n) * 2 - $urandom_range(0, 3);
      else if ($urandom_range(0, 5) != 0) xv = xv + $urandom_range(1, 1 << 18);
    end
  endtask

  function automatic logic [31:0] pick_query(int n);
    int k;
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return bp_xs[k];
      2: return bp_xs[k] + 1;
      3: return bp_xs[k] - 1;
      default: return bp_xs[k] + $urandom_range(0, 1 << 18);
    endcase
  endfunction

  initial begin
    int n;
    int sent;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    sink_on = 1;

    // Directed: full table at reset length, extreme values
    load_table(256, 1);
    send_word(OP_QUERY, 0, 32'h8000_0000, 32'hffff_ffff);
    send_word(OP_QUERY, 255, 32'h7fff_ffff, 32'h0);
    send_word(OP_QUERY, 0, bp_xs[100], 32'h0);
    send_word(OP_QUERY, 0, bp_xs[100] + 7, 32'h0);
    send_word(OP_QUERY, 0, bp_xs[255] - 1, 32'h0);
    // Length below the minimum, and above the maximum
    drain_then_set_len(0);
    send_word(OP_QUERY, 0, bp_xs[0] + 5, 32'h0);
    drain_then_set_len(1);
    send_word(OP_QUERY, 0, bp_xs[1] + 5, 32'h0);
    drain_then_set_len(2);
    send_word(OP_QUERY, 0, bp_xs[0] + 1, 32'h0);
    drain_then_set_len(511);
    send_word(OP_QUERY, 0, bp_xs[200] + 3, 32'h0);
    // Unordered table and zero-width segment
    drain_then_set_len(4);
    send_word(OP_WRITE, 0, 32'sd0, 32'sd100);
    send_word(OP_WRITE, 1, 32'sd0, 32'sd200);
    send_word(OP_WRITE, 2, -32'sd50, 32'h7fff_ffff);
    send_word(OP_WRITE, 3, 32'sd1000, 32'h8000_0000);
    bp_xs[0] = 0; bp_xs[1] = 0; bp_xs[2] = -50; bp_xs[3] = 1000;
    send_word(OP_QUERY, 0, 32'sd10, 32'h0);
    send_word(OP_QUERY, 0, 32'sd999, 32'h0);
    send_word(OP_QUERY, 0, 32'sd0, 32'h0);

    // Random phases: mostly small tables, a few long ones
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) n = $urandom_range(100, 256);
      else n = $urandom_range(2, 12);
      drain_then_set_len(n);
      load_table(n, $urandom_range(0, 3) == 0);
      sent += n;
      repeat ($urandom_range(20, 40)) begin
        // Occasionally rewrite an entry with the same x
        if ($urandom_range(0, 9) == 0) begin
          int k;
          k = $urandom_range(0, n - 1);
          send_word(OP_WRITE, k, bp_xs[k], $urandom());
        end else begin
          send_word(OP_QUERY, $urandom_range(0, 255), pick_query(n), $urandom());
        end
        sent++;
      end
      if (sent > RANDOM_ITEMS - 200) quiet_tail = 1;
    end

    // Wait for the last results, then give the verdict
    while (pending_count != 0) @(negedge clk);
    repeat (700) @(negedge clk);
    if (fail_count == 0) begin
      $display("table_linear_interpolator: match");
    end else begin
      $display("table_linear_interpolator: mismatch");
    end
    $finish;
  end
endmodule

// File: sim.f
hdl/tli_pkg.sv
hdl/tli_front.sv
hdl/tli_back.sv
hdl/table_linear_interpolator.sv
tb/tli_checker.sv
tb/tb_top.sv
